// ===== rtl/iagcd_pkg.sv =====
// Shared types and constants for the integer ALU with gcd.
`default_nettype none

package iagcd_pkg;

	// Default operand width
	localparam int DATA_WIDTH_DEF = 32;

	// Width of the operation selector
	localparam int KIND_W = 3;

	// Operation codes
	typedef enum logic [KIND_W-1:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_REM = 3'd4,
		KIND_GCD = 3'd5
	} kind_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADDS,
		ST_NEG_A,
		ST_NEG_B,
		ST_MUL,
		ST_DIV,
		ST_FIX,
		ST_GCD,
		ST_GSHIFT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/integer_alu_with_gcd.sv =====
// Integer ALU top level: add, subtract, multiply, divide, remainder and gcd.
`default_nettype none

// Signed integer ALU on two DATA_WIDTH-bit operands. One request is taken at a
// time; a finished result sits in an output register, so the next request is
// accepted while it waits. All adding and subtracting goes through one shared (DATA_WIDTH+1)-bit
// adder, one radix-2 step per cycle, operands held in shift registers.
// Steps from acceptance to result valid: add and subtract take one adder pass;
// multiply takes one multiplier bit a cycle; divide and remainder run operand
// negation (ST_NEG_A, ST_NEG_B), one quotient bit a cycle, then sign
// correction (ST_FIX); divide by zero and unused codes go straight to ST_DONE;
// gcd is binary (Stein) with one shift, swap or subtract a cycle, its number
// of steps set by the operand values.
// Divide or remainder by zero returns 0 with status 1.

module integer_alu_with_gcd #(
	parameter int DATA_WIDTH = iagcd_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// request channel
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// left_operand, right_operand
	input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
	// kind
	input  wire logic [iagcd_pkg::KIND_W-1:0]          s_tuser,
	// result channel
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// result
	output logic [((DATA_WIDTH+7)/8)*8-1:0]            m_tdata,
	// status
	output logic [0:0]                                 m_tuser
);

	localparam int W       = DATA_WIDTH;
	localparam int CW      = $clog2(W);
	localparam int OUT_W   = ((W+7)/8)*8;

	iagcd_pkg::state_t state_q, state_d;

	logic [iagcd_pkg::KIND_W-1:0] kind_q;
	logic [W-1:0]  a_q, b_q;
	logic [W:0]    r_q;
	logic [CW-1:0] cnt_q, k_q;
	logic          neg_a_q, neg_b_q, fneg_q, status_q;

	logic [W-1:0]  in_left, in_right;
	logic [W:0]    add_x, add_y;
	logic          add_inv;
	logic [W+1:0]  add_sum;
	logic          carry;
	logic          cnt_last, a_zero, b_zero, out_free, in_acc;
	logic [W:0]    rem_sh;

	assign in_left  = s_tdata[W-1:0];
	assign in_right = s_tdata[2*W-1:W];
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign cnt_last = (cnt_q == CW'(W-1));
	assign a_zero   = (a_q == '0);
	assign b_zero   = (b_q == '0);
	assign rem_sh   = {r_q[W-1:0], a_q[W-1]};

	// shared adder / subtractor
	assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(W+1){add_inv}}} + (W+2)'(add_inv);
	assign carry   = add_sum[W+1];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iagcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, adder operand selection
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		add_x    = {1'b0, a_q};
		add_y    = {1'b0, b_q};
		add_inv  = 1'b0;
		case (state_q)
			iagcd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (s_tuser)
						iagcd_pkg::KIND_ADD,
						iagcd_pkg::KIND_SUB: state_d = iagcd_pkg::ST_ADDS;
						iagcd_pkg::KIND_MUL: state_d = iagcd_pkg::ST_MUL;
						iagcd_pkg::KIND_DIV,
						iagcd_pkg::KIND_REM: begin
							state_d = (in_right == '0) ? iagcd_pkg::ST_DONE
							                           : iagcd_pkg::ST_NEG_A;
						end
						iagcd_pkg::KIND_GCD: state_d = iagcd_pkg::ST_NEG_A;
						default:             state_d = iagcd_pkg::ST_DONE;
					endcase
				end
			end
			iagcd_pkg::ST_ADDS: begin
				add_inv = (kind_q == iagcd_pkg::KIND_SUB);
				state_d = iagcd_pkg::ST_DONE;
			end
			iagcd_pkg::ST_NEG_A: begin
				add_x   = '0;
				add_y   = {1'b0, a_q};
				add_inv = 1'b1;
				state_d = iagcd_pkg::ST_NEG_B;
			end
			iagcd_pkg::ST_NEG_B: begin
				add_x   = '0;
				add_y   = {1'b0, b_q};
				add_inv = 1'b1;
				state_d = (kind_q == iagcd_pkg::KIND_GCD) ? iagcd_pkg::ST_GCD
				                                          : iagcd_pkg::ST_DIV;
			end
			iagcd_pkg::ST_MUL: begin
				add_x = {1'b0, r_q[W-1:0]};
				add_y = {1'b0, a_q};
				if (cnt_last) begin
					state_d = iagcd_pkg::ST_DONE;
				end
			end
			iagcd_pkg::ST_DIV: begin
				add_x   = rem_sh;
				add_y   = {1'b0, b_q};
				add_inv = 1'b1;
				if (cnt_last) begin
					state_d = iagcd_pkg::ST_FIX;
				end
			end
			iagcd_pkg::ST_FIX: begin
				add_x   = '0;
				add_y   = r_q;
				add_inv = 1'b1;
				state_d = iagcd_pkg::ST_DONE;
			end
			iagcd_pkg::ST_GCD: begin
				add_inv = 1'b1;
				if (a_zero || b_zero) begin
					state_d = iagcd_pkg::ST_GSHIFT;
				end
			end
			iagcd_pkg::ST_GSHIFT: begin
				if (k_q == '0) begin
					state_d = iagcd_pkg::ST_DONE;
				end
			end
			iagcd_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = iagcd_pkg::ST_IDLE;
				end
			end
			default: state_d = iagcd_pkg::ST_IDLE;
		endcase
	end

	// datapath: operand shift registers, accumulator, counters
	always_ff @(posedge clk) begin
		case (state_q)
			iagcd_pkg::ST_IDLE: begin
				if (in_acc) begin
					kind_q   <= s_tuser;
					a_q      <= in_left;
					b_q      <= in_right;
					neg_a_q  <= in_left[W-1];
					neg_b_q  <= in_right[W-1];
					r_q      <= '0;
					cnt_q    <= '0;
					k_q      <= '0;
					status_q <= (s_tuser inside {iagcd_pkg::KIND_DIV, iagcd_pkg::KIND_REM})
					            && (in_right == '0);
				end
			end
			iagcd_pkg::ST_ADDS: begin
				r_q <= add_sum[W:0];
			end
			iagcd_pkg::ST_NEG_A: begin
				if (neg_a_q) begin
					a_q <= add_sum[W-1:0];
				end
			end
			iagcd_pkg::ST_NEG_B: begin
				if (neg_b_q) begin
					b_q <= add_sum[W-1:0];
				end
			end
			// one multiplier bit a cycle, low word only
			iagcd_pkg::ST_MUL: begin
				if (b_q[0]) begin
					r_q <= add_sum[W:0];
				end
				a_q   <= {a_q[W-2:0], 1'b0};
				b_q   <= {1'b0, b_q[W-1:1]};
				cnt_q <= cnt_q + CW'(1);
			end
			// restoring division, quotient shifts into a_q
			iagcd_pkg::ST_DIV: begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_last) begin
					if (kind_q == iagcd_pkg::KIND_DIV) begin
						r_q    <= {1'b0, a_q[W-2:0], carry};
						fneg_q <= neg_a_q ^ neg_b_q;
					end else begin
						r_q    <= carry ? add_sum[W:0] : rem_sh;
						fneg_q <= neg_a_q;
					end
				end else begin
					a_q <= {a_q[W-2:0], carry};
					r_q <= carry ? add_sum[W:0] : rem_sh;
				end
			end
			iagcd_pkg::ST_FIX: begin
				if (fneg_q) begin
					r_q <= add_sum[W:0];
				end
			end
			// binary gcd: strip common twos, strip lone twos, subtract smaller
			iagcd_pkg::ST_GCD: begin
				if (a_zero || b_zero) begin
					r_q <= {1'b0, a_q | b_q};
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= {1'b0, a_q[W-1:1]};
					b_q <= {1'b0, b_q[W-1:1]};
					k_q <= k_q + CW'(1);
				end else if (!a_q[0]) begin
					a_q <= {1'b0, a_q[W-1:1]};
				end else if (!b_q[0]) begin
					b_q <= {1'b0, b_q[W-1:1]};
				end else if (carry) begin
					a_q <= add_sum[W-1:0];
				end else begin
					a_q <= b_q;
					b_q <= a_q;
				end
			end
			// restore the common power of two
			iagcd_pkg::ST_GSHIFT: begin
				if (k_q != '0) begin
					r_q <= {r_q[W-1:0], 1'b0};
					k_q <= k_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == iagcd_pkg::ST_DONE && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == iagcd_pkg::ST_DONE && out_free) begin
			m_tdata <= OUT_W'(r_q[W-1:0]);
			m_tuser <= status_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iagcd_checker.sv =====
// Port-level checker for the integer ALU with gcd, bound to the top level.
`default_nettype none

module iagcd_checker #(
	parameter int DATA_WIDTH = iagcd_pkg::DATA_WIDTH_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	input wire logic [iagcd_pkg::KIND_W-1:0]      s_tuser,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
	input wire logic [0:0]                        m_tuser
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without an accepted request");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests in flight");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[DATA_WIDTH-1:0] == '0)
		else $error("divide by zero with non-zero result");

endmodule

bind integer_alu_with_gcd iagcd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_iagcd_checker (.*);

`default_nettype wire

// ===== dv/alu_result_checker.sv =====
// Result checker for the integer ALU: predicts each outcome and compares the result stream.

module alu_result_checker
	import iagcd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	// left_operand, right_operand
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
	// kind
	input  logic [KIND_W-1:0]                     s_tuser,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	// result
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
	// status
	input  logic [0:0]                            m_tuser,
	output int                                    fail_count,
	output int                                    results_seen
);

	localparam int W = DATA_WIDTH;

	typedef struct packed {
		logic [W-1:0] value;
		logic         status;
	} alu_outcome_t;

	// outcomes of accepted requests, oldest first
	alu_outcome_t expected_outcomes[$];

	initial begin
		fail_count = 0;
		results_seen = 0;
	end

	// value and status that one request must produce
	function automatic alu_outcome_t compute_outcome(input logic [KIND_W-1:0] kind,
			input logic [W-1:0] lhs, input logic [W-1:0] rhs);
		alu_outcome_t o;
		logic [W-1:0] mag_l, mag_r, quo, rem, x, y, t;
		o = '0;
		mag_l = lhs[W-1] ? -lhs : lhs;
		mag_r = rhs[W-1] ? -rhs : rhs;
		case (kind)
			KIND_ADD: o.value = lhs + rhs;
			KIND_SUB: o.value = lhs - rhs;
			KIND_MUL: o.value = lhs * rhs;
			KIND_DIV, KIND_REM: begin
				if (rhs == '0) begin
					o.status = 1'b1;
				end else begin
					// work on magnitudes, then restore the signs
					quo = mag_l / mag_r;
					rem = mag_l % mag_r;
					if (kind == KIND_DIV)
						o.value = (lhs[W-1] ^ rhs[W-1]) ? -quo : quo;
					else
						o.value = lhs[W-1] ? -rem : rem;
				end
			end
			KIND_GCD: begin
				// Euclid on magnitudes; the most negative value keeps its bit pattern
				x = mag_l;
				y = mag_r;
				while (y != '0) begin
					t = x % y;
					x = y;
					y = t;
				end
				o.value = x;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic flag_mismatch(input string what, input alu_outcome_t want,
			input alu_outcome_t got);
		if (fail_count < 10)
			$display("%0t: %s: expected result %h (%0d) status %b, got result %h (%0d) status %b",
				$realtime, what, want.value, $signed(want.value), want.status,
				got.value, $signed(got.value), got.status);
		fail_count++;
	endtask

	// results are checked before the same edge's request is queued
	always @(posedge clk) begin : watch
		alu_outcome_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.value = m_tdata[W-1:0];
				got.status = m_tuser[0];
				results_seen <= results_seen + 1;
				if (expected_outcomes.size() == 0) begin
					flag_mismatch("result with no request outstanding", '0, got);
				end else begin
					want = expected_outcomes.pop_front();
					if (got.value !== want.value || got.status !== want.status)
						flag_mismatch("mismatch", want, got);
				end
			end
			if (s_tvalid && s_tready)
				expected_outcomes.push_back(compute_outcome(s_tuser,
					s_tdata[W-1:0], s_tdata[2*W-1:W]));
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Testbench top for the integer ALU: clock, reset, request stimulus, result sink and verdict.

module testbench;
	import iagcd_pkg::*;

	localparam int W = DATA_WIDTH_DEF;
	localparam logic [W-1:0] OPND_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] OPND_MAX = {1'b0, {(W-1){1'b1}}};
	// codes outside the operation set, answered with zero
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 900;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_LIMIT = 4000;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	// left_operand, right_operand
	logic [((2*W+7)/8)*8-1:0]          s_tdata;
	// kind
	logic [KIND_W-1:0]                 s_tuser;
	logic                              m_tvalid;
	logic                              m_tready;
	// result
	logic [((W+7)/8)*8-1:0]            m_tdata;
	// status
	logic [0:0]                        m_tuser;

	int fail_count;
	int results_seen;
	int items_sent;
	bit hold_off_req;

	integer_alu_with_gcd #(
		.DATA_WIDTH(W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	alu_result_checker #(
		.DATA_WIDTH(W)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// offer one request and hold it until the block takes it
	task automatic push_request(input logic [KIND_W-1:0] kind, input logic [W-1:0] lhs,
			input logic [W-1:0] rhs);
		s_tvalid <= 1'b1;
		s_tdata <= {rhs, lhs};
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// operand drawn from edge values, powers of two, small values and full-range noise
	function automatic logic [W-1:0] pick_operand();
		logic [W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = OPND_MIN;
			1: v = OPND_MAX;
			2: v = '0;
			3: v = '1;
			4: v = 1;
			5: v = W'(1) << $urandom_range(0, W-1);
			6, 7: v = $urandom_range(0, 300);
			default: v = $urandom;
		endcase
		if ($urandom_range(0, 3) == 0)
			v = -v;
		return v;
	endfunction

	task automatic random_request();
		logic [KIND_W-1:0] kind;
		logic [W-1:0] lhs, rhs, factor;
		kind = KIND_W'($urandom_range(KIND_ADD, KIND_GCD));
		lhs = pick_operand();
		rhs = pick_operand();
		// shared factor so that gcd results are not mostly one
		if (kind == KIND_GCD && $urandom_range(0, 1)) begin
			factor = $urandom_range(1, 5000);
			lhs = factor * $urandom_range(0, 3000);
			rhs = factor * $urandom_range(0, 3000);
			if ($urandom_range(0, 1))
				lhs = -lhs;
			if ($urandom_range(0, 1))
				rhs = -rhs;
		end
		push_request(kind, lhs, rhs);
	endtask

	// request stimulus and verdict
	initial begin : stimulus
		int burst, gap, target;
		bit drained_mid;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		hold_off_req = 1'b0;
		items_sent = 0;
		drained_mid = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wrap-around of add, subtract and multiply
		push_request(KIND_ADD, OPND_MAX, 1);
		push_request(KIND_ADD, OPND_MIN, -1);
		push_request(KIND_SUB, OPND_MIN, 1);
		push_request(KIND_SUB, 0, OPND_MIN);
		push_request(KIND_MUL, OPND_MAX, OPND_MAX);
		push_request(KIND_MUL, OPND_MIN, -1);
		push_request(KIND_MUL, -3, 7);
		// truncation toward zero, divide by zero, most negative over minus one
		push_request(KIND_DIV, 7, -2);
		push_request(KIND_DIV, -7, 2);
		push_request(KIND_DIV, OPND_MAX, 0);
		push_request(KIND_DIV, OPND_MIN, -1);
		push_request(KIND_DIV, 0, 5);
		// remainder takes the dividend's sign; remainder by zero, most negative over minus one
		push_request(KIND_REM, -7, 2);
		push_request(KIND_REM, 7, -2);
		push_request(KIND_REM, OPND_MIN, 0);
		push_request(KIND_REM, OPND_MIN, -1);
		// gcd of zeros, of the most negative value, and ordinary cases; then the unused codes
		push_request(KIND_GCD, 0, 0);
		push_request(KIND_GCD, OPND_MIN, 0);
		push_request(KIND_GCD, OPND_MIN, OPND_MIN);
		push_request(KIND_GCD, -12, 18);
		push_request(KIND_GCD, OPND_MAX, 1);
		push_request(KIND_GCD, 48, 0);
		push_request(KIND_SPARE_LO, OPND_MAX, OPND_MIN);
		push_request(KIND_SPARE_HI, -1, -1);
		s_tvalid <= 1'b0;
		wait (results_seen == items_sent);
		@(posedge clk);

		// sink holds off while requests keep coming, so the block backs up
		hold_off_req = 1'b1;
		repeat (16) random_request();

		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			burst = $urandom_range(1, 20);
			repeat (burst) random_request();
			if (!drained_mid && items_sent >= target - RANDOM_ITEMS / 2) begin
				// let everything drain once in the middle of the run
				s_tvalid <= 1'b0;
				wait (results_seen == items_sent);
				@(posedge clk);
				drained_mid = 1'b1;
			end else begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		s_tvalid <= 1'b0;

		wait (results_seen == items_sent);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_seen == items_sent)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result sink: ready patterns in spans, plus one long hold-off on request
	initial begin : result_sink
		int mode, span, tick;
		bit held;
		held = 1'b0;
		tick = 0;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 60);
			repeat (span) begin
				if (hold_off_req && !held) begin
					held = 1'b1;
					m_tready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((tick % 5) < 3);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	// watchdog: too long without any handshake on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/iagcd_pkg.sv
rtl/integer_alu_with_gcd.sv
rtl/iagcd_checker.sv
dv/alu_result_checker.sv
dv/testbench.sv
